[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/lscae_pkg.sv]
// ----------------------------------------------------------------------------
// lscae_pkg
// Types and constants of the line sensor calibration and error core.
// ----------------------------------------------------------------------------
package lscae_pkg;

    localparam int FRAME_CHANNELS = 10;
    localparam int NUM_CHANNELS   = 10;
    localparam int WINDOW_DEPTH   = 10;
    localparam int OFFSET_PAIRS   = 4;
    localparam int CH_IDX_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Window sum and magnitude widths
    localparam int SUM_W = 14 + $clog2(WINDOW_DEPTH);
    localparam int MAG_W = SUM_W - 1;

    // Reciprocal divide by the window depth, exact for magnitudes below 2**16
    localparam int DIV_SHIFT = 24;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'((2**DIV_SHIFT + WINDOW_DEPTH - 1) / WINDOW_DEPTH);

    typedef logic [11:0]        t_sample;
    typedef logic [3:0]         t_chan;
    typedef logic signed [12:0] t_diff;
    typedef logic signed [13:0] t_error;
    typedef logic signed [8:0]  t_offset;
    typedef logic [1:0]         t_cfg_idx;

    localparam t_cfg_idx CFG_LEFT_CHANNEL    = 2'd0;
    localparam t_cfg_idx CFG_RIGHT_CHANNEL   = 2'd1;
    localparam t_cfg_idx CFG_WHITE_THRESHOLD = 2'd2;

    localparam t_chan   RST_LEFT_CHANNEL    = 4'd4;
    localparam t_chan   RST_RIGHT_CHANNEL   = 4'd5;
    localparam t_sample RST_WHITE_THRESHOLD = 12'd2000;

    localparam t_sample SAMPLE_FULL     = 12'd4095;
    localparam t_sample SATURATED_LEVEL = 12'd4090;

    typedef struct packed {
        t_chan   left_channel;
        t_chan   right_channel;
        t_sample white_threshold;
    } t_cfg;

    typedef struct packed {
        t_sample sample;
        t_sample minimum;
        logic    hit;
    } t_lane_out;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    first_nz;
        t_diff                   min_diff;
        t_offset                 offset;
    } t_merge_out;

    function automatic t_offset offset_mag(input logic [1:0] k);
        t_offset m;
        unique case (k)
            2'd0:    m = 9'sd150;
            2'd1:    m = 9'sd120;
            2'd2:    m = 9'sd90;
            default: m = 9'sd50;
        endcase
        return m;
    endfunction

endpackage

[rtl/core/lscae_in_if.sv]
// ----------------------------------------------------------------------------
// lscae_in_if
// Sample frame channel: ten 12-bit sensor samples with valid/ready.
// ----------------------------------------------------------------------------
interface lscae_in_if;
    import lscae_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_ch0;
    t_sample sample_ch1;
    t_sample sample_ch2;
    t_sample sample_ch3;
    t_sample sample_ch4;
    t_sample sample_ch5;
    t_sample sample_ch6;
    t_sample sample_ch7;
    t_sample sample_ch8;
    t_sample sample_ch9;

    modport source (
        output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4,
               sample_ch5, sample_ch6, sample_ch7, sample_ch8, sample_ch9,
        input  ready
    );
    modport sink (
        input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4,
               sample_ch5, sample_ch6, sample_ch7, sample_ch8, sample_ch9,
        output ready
    );
endinterface

[rtl/core/lscae_out_if.sv]
// ----------------------------------------------------------------------------
// lscae_out_if
// Result channel: window average, compensated error and position offset.
// ----------------------------------------------------------------------------
interface lscae_out_if;
    import lscae_pkg::*;

    logic    valid;
    logic    ready;
    t_diff   window_average;
    t_error  compensated_error;
    t_offset position_offset;

    modport source (
        output valid, window_average, compensated_error, position_offset,
        input  ready
    );
    modport sink (
        input  valid, window_average, compensated_error, position_offset,
        output ready
    );
endinterface

[rtl/core/lscae_cfg_if.sv]
// ----------------------------------------------------------------------------
// lscae_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ----------------------------------------------------------------------------
interface lscae_cfg_if;
    import lscae_pkg::*;

    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_sample  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/lscae_lane.sv]
// ----------------------------------------------------------------------------
// lscae_lane
// One sensor channel: running minimum and maximum, threshold compare.
// ----------------------------------------------------------------------------
module lscae_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  lscae_pkg::t_sample    i_sample,
    input  lscae_pkg::t_sample    i_threshold,
    output lscae_pkg::t_lane_out  o_lane
);
    import lscae_pkg::*;

    t_sample r_min;
    t_sample r_max;
    t_sample r_sample;
    logic    r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= SAMPLE_FULL;
            r_max <= '0;
        end else if (i_load) begin
            // a zero sample never lowers the minimum
            if (i_sample != '0 && i_sample < r_min) begin
                r_min <= i_sample;
            end
            if (i_sample > r_max) begin
                r_max <= i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sample <= i_sample;
            r_hit    <= (i_sample > i_threshold);
        end
    end

    assign o_lane.sample  = r_sample;
    assign o_lane.minimum = r_min;
    assign o_lane.hit     = r_hit;
endmodule

[rtl/core/lscae_merge.sv]
// ----------------------------------------------------------------------------
// lscae_merge
// Merge stage: channel select, difference window with running sum,
// minima difference and priority position offset.
// ----------------------------------------------------------------------------
module lscae_merge (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lscae_pkg::t_cfg        i_cfg,
    input  lscae_pkg::t_lane_out   i_lane [lscae_pkg::NUM_CHANNELS],
    input  logic                   i_valid,
    output logic                   o_ready,
    output logic                   o_valid,
    input  logic                   i_ready,
    output lscae_pkg::t_merge_out  o_data
);
    import lscae_pkg::*;

    t_diff                   r_win [WINDOW_DEPTH];
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic                    r_valid;
    t_merge_out              r_data;

    t_chan                   w_lc_full;
    t_chan                   w_rc_full;
    logic [CH_IDX_W-1:0]     w_lc;
    logic [CH_IDX_W-1:0]     w_rc;
    t_sample                 w_s_l;
    t_sample                 w_s_r;
    t_diff                   w_diff;
    t_diff                   w_min_diff;
    logic                    w_first_nz;
    t_offset                 w_off;
    logic                    w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    // saturate channel indexes beyond the last channel
    assign w_lc_full = (i_cfg.left_channel >= 4'(NUM_CHANNELS)) ?
                       4'(NUM_CHANNELS - 1) : i_cfg.left_channel;
    assign w_rc_full = (i_cfg.right_channel >= 4'(NUM_CHANNELS)) ?
                       4'(NUM_CHANNELS - 1) : i_cfg.right_channel;
    assign w_lc = w_lc_full[CH_IDX_W-1:0];
    assign w_rc = w_rc_full[CH_IDX_W-1:0];

    assign w_s_l  = i_lane[w_lc].sample;
    assign w_s_r  = i_lane[w_rc].sample;
    assign w_diff = $signed({1'b0, w_s_l}) - $signed({1'b0, w_s_r});

    always_comb begin
        w_min_diff = $signed({1'b0, i_lane[w_lc].minimum}) -
                     $signed({1'b0, i_lane[w_rc].minimum});
        // drop the minima term when both channels are saturated
        if (w_s_l >= SATURATED_LEVEL && w_s_r >= SATURATED_LEVEL) begin
            w_min_diff = '0;
        end
    end

    // sum after the push: drop the oldest entry, add the new difference
    assign n_sum = r_sum - SUM_W'(r_win[0]) + SUM_W'(w_diff);

    generate
        if (WINDOW_DEPTH > 1) begin : g_first_deep
            assign w_first_nz = (r_win[1] != '0);
        end else begin : g_first_single
            assign w_first_nz = (w_diff != '0);
        end
    endgenerate

    // lowest pair wins; inside a pair the near channel wins
    always_comb begin
        w_off = '0;
        for (int k = OFFSET_PAIRS - 1; k >= 0; k--) begin
            if (k < NUM_CHANNELS - 1 - k) begin
                if (i_lane[NUM_CHANNELS - 1 - k].hit) begin
                    w_off = -offset_mag(2'(k));
                end
                if (i_lane[k].hit) begin
                    w_off = offset_mag(2'(k));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sum   <= '0;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_load) begin
                for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                    r_win[i] <= r_win[i + 1];
                end
                r_win[WINDOW_DEPTH - 1] <= w_diff;
                r_sum <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data.sum      <= n_sum;
            r_data.first_nz <= w_first_nz;
            r_data.min_diff <= w_min_diff;
            r_data.offset   <= w_off;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

[rtl/core/lscae_avg.sv]
// ----------------------------------------------------------------------------
// lscae_avg
// Window mean by reciprocal multiply, sign restore and error compensation,
// with the output register.
// ----------------------------------------------------------------------------
module lscae_avg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lscae_pkg::t_merge_out  i_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    output logic                   o_valid,
    input  logic                   i_ready,
    output lscae_pkg::t_diff       o_avg,
    output lscae_pkg::t_error      o_error,
    output lscae_pkg::t_offset     o_offset
);
    import lscae_pkg::*;

    localparam int PROD_W = MAG_W + RECIP_W;

    logic                    r_v3;
    logic                    r_v4;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_neg;
    logic                    r_first_nz;
    t_diff                   r_min_diff;
    t_offset                 r_off3;
    t_diff                   r_avg;
    t_error                  r_error;
    t_offset                 r_off4;

    logic                    w_en3;
    logic                    w_en4;
    logic signed [SUM_W-1:0] w_abs;
    logic [MAG_W-1:0]        w_mag;
    logic [PROD_W-1:0]       n_prod;
    logic [MAG_W-1:0]        w_quot;
    t_diff                   w_avg_mag;
    t_diff                   n_avg;
    t_error                  n_error;

    assign w_en4   = !r_v4 || i_ready;
    assign w_en3   = !r_v3 || w_en4;
    assign o_ready = w_en3;

    assign w_abs  = i_data.sum[SUM_W-1] ? -i_data.sum : i_data.sum;
    assign w_mag  = w_abs[MAG_W-1:0];
    assign n_prod = PROD_W'(w_mag) * PROD_W'(DIV_RECIP);

    assign w_quot    = r_prod[DIV_SHIFT +: MAG_W];
    assign w_avg_mag = $signed({1'b0, w_quot[11:0]});

    always_comb begin
        n_avg = '0;
        if (r_first_nz) begin
            n_avg = r_neg ? -w_avg_mag : w_avg_mag;
        end
    end

    assign n_error = 14'(n_avg) - 14'(r_min_diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en3) begin
                r_v3 <= i_valid;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3 && i_valid) begin
            r_prod     <= n_prod;
            r_neg      <= i_data.sum[SUM_W-1];
            r_first_nz <= i_data.first_nz;
            r_min_diff <= i_data.min_diff;
            r_off3     <= i_data.offset;
        end
        if (w_en4 && r_v3) begin
            r_avg   <= n_avg;
            r_error <= n_error;
            r_off4  <= r_off3;
        end
    end

    assign o_valid  = r_v4;
    assign o_avg    = r_avg;
    assign o_error  = r_error;
    assign o_offset = r_off4;
endmodule

[rtl/core/line_sensor_calibrate_and_error_core.sv]
// Throughput: one frame per cycle while the output channel is not stalled; set by
// the four-stage pipeline (lanes, merge, reciprocal multiply, output register),
// each stage moving whenever the next frees.
// Reset (synchronous, active low): minima to 4095, maxima and difference window to
// zero, registers to left 4 / right 5 / threshold 2000, pipeline emptied.
// ----------------------------------------------------------------------------
// line_sensor_calibrate_and_error_core
// Per-channel calibration lanes, a merge stage for window average and offset,
// and a divide/compensate stage feeding the result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_sensor_calibrate_and_error_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lscae_in_if.sink    i_in,
    lscae_cfg_if.sink   i_cfg,
    lscae_out_if.source o_out
);
    import lscae_pkg::*;

    t_cfg       r_cfg;
    logic       r_v1;
    logic       w_en1;
    logic       w_load1;
    logic       w_ready2;
    logic       w_valid2;
    logic       w_ready3;
    t_merge_out w_merge;
    t_sample    w_frame [FRAME_CHANNELS];
    t_lane_out  w_lane  [NUM_CHANNELS];

    // configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_channel    <= RST_LEFT_CHANNEL;
            r_cfg.right_channel   <= RST_RIGHT_CHANNEL;
            r_cfg.white_threshold <= RST_WHITE_THRESHOLD;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_LEFT_CHANNEL:    r_cfg.left_channel    <= i_cfg.data[3:0];
                CFG_RIGHT_CHANNEL:   r_cfg.right_channel   <= i_cfg.data[3:0];
                CFG_WHITE_THRESHOLD: r_cfg.white_threshold <= i_cfg.data;
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // lane stage handshake
    assign w_en1      = !r_v1 || w_ready2;
    assign i_in.ready = w_en1;
    assign w_load1    = i_in.valid && w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en1) begin
            r_v1 <= i_in.valid;
        end
    end

    assign w_frame[0] = i_in.sample_ch0;
    assign w_frame[1] = i_in.sample_ch1;
    assign w_frame[2] = i_in.sample_ch2;
    assign w_frame[3] = i_in.sample_ch3;
    assign w_frame[4] = i_in.sample_ch4;
    assign w_frame[5] = i_in.sample_ch5;
    assign w_frame[6] = i_in.sample_ch6;
    assign w_frame[7] = i_in.sample_ch7;
    assign w_frame[8] = i_in.sample_ch8;
    assign w_frame[9] = i_in.sample_ch9;

    generate
        for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
            lscae_lane u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_load      (w_load1),
                .i_sample    (w_frame[g]),
                .i_threshold (r_cfg.white_threshold),
                .o_lane      (w_lane[g])
            );
        end
    endgenerate

    lscae_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_lane  (w_lane),
        .i_valid (r_v1),
        .o_ready (w_ready2),
        .o_valid (w_valid2),
        .i_ready (w_ready3),
        .o_data  (w_merge)
    );

    lscae_avg u_avg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (w_merge),
        .i_valid  (w_valid2),
        .o_ready  (w_ready3),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_avg    (o_out.window_average),
        .o_error  (o_out.compensated_error),
        .o_offset (o_out.position_offset)
    );

    // an empty output register lets the whole pipeline advance
    `ASSERT_CLK(a_ready_when_out_free, !o_out.valid |-> i_in.ready, "input stalled with free output")
    `ASSERT_CLK(a_accept_fills_lane, (i_in.valid && i_in.ready) |=> r_v1, "accepted frame lost at lane stage")
    `ASSERT_CLK(a_lane_holds_on_stall, (r_v1 && !w_ready2) |=> r_v1, "lane stage dropped a stalled frame")
    `ASSERT_ALWAYS(a_reset_empties_lane, !$past(i_rst_n) |-> !r_v1, "lane stage valid after reset")
endmodule
